### hw/rtl/dfra_pkg.sv
// Shared constants and codes for the route admission block.
// No dependencies; imported by deadlock_free_route_admission.
package dfra_pkg;

    localparam int STATIONS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam int STOP_W    = 2;
    localparam int LEN_W     = 3;
    localparam int MAX_STOPS = 4;
    localparam int STEP_W    = 2;

    typedef enum logic
    {
        FUNC_ADMIT   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

endpackage

### hw/rtl/deadlock_free_route_admission.sv
// Route admission over a resource-order graph of edge counts between stations.
// Depends on dfra_pkg for codes and default sizes.
//
// Usage. A command beat is taken at a rising edge where start is high and busy
// is low; the beat carries func, route_length, stop_0..stop_3, edge_from and
// edge_to. Every command gives exactly one result beat: done is high for one
// cycle with admitted and fault valid alongside it. The receiver cannot stall,
// so the result must be captured in that cycle. busy is high from the cycle
// after acceptance until the result cycle, in which a new command may be taken.
//
// Sequence, from the accepting edge to the cycle in which done is high:
// a release, a single-stop route or a route with a station out of range gives
// its result from the release or check state. A longer route of len stops
// marks its edges one per cycle, runs a Warshall closure one pivot station per
// cycle over all STATIONS pivots and checks the diagonal; a refused route
// reports from the verdict state, an admitted one commits its edges one per
// cycle through the single saturating incrementer and reports with its last
// commit.
//
// Reset clears every edge count, the sequencer and the result strobe.
module deadlock_free_route_admission
    import dfra_pkg::*;
#(
    parameter int STATIONS    = STATIONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [LEN_W-1:0]    route_length,
    input  logic [STOP_W-1:0]   stop_0,
    input  logic [STOP_W-1:0]   stop_1,
    input  logic [STOP_W-1:0]   stop_2,
    input  logic [STOP_W-1:0]   stop_3,
    input  logic [STOP_W-1:0]   edge_from,
    input  logic [STOP_W-1:0]   edge_to,
    output logic                done,
    output logic                admitted,
    output logic                fault
);

    // Station indices use only the bits needed to address STATIONS rows.
    localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    // Limit against which a two-bit stop is compared; one extra bit holds it.
    localparam logic [STOP_W:0] STOP_LIMIT = (STOP_W + 1)'(STATIONS);
    localparam logic [IDX_W-1:0] LAST_PIVOT = IDX_W'(STATIONS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [STATIONS-1:0]    row_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_CHECK,
        S_EDGE,
        S_CLOSE,
        S_VERDICT,
        S_COMMIT,
        S_RELEASE
    } state_t;

    state_t              state_reg,    state_next;
    func_t               func_reg,     func_next;
    logic [LEN_W-1:0]    len_reg,      len_next;
    logic [STOP_W-1:0]   stops_reg     [MAX_STOPS];
    logic [STOP_W-1:0]   stops_next    [MAX_STOPS];
    logic [STOP_W-1:0]   from_reg,     from_next;
    logic [STOP_W-1:0]   to_reg,       to_next;
    logic [STEP_W-1:0]   step_reg,     step_next;
    logic [IDX_W-1:0]    pivot_reg,    pivot_next;
    logic                sat_reg,      sat_next;
    row_t                reach_reg     [STATIONS];
    row_t                reach_next    [STATIONS];
    count_t              counts_reg    [STATIONS][STATIONS];
    count_t              counts_next   [STATIONS][STATIONS];
    logic                done_reg,     done_next;
    logic                admitted_reg, admitted_next;
    logic                fault_reg,    fault_next;

    // Shared datapath signals.
    logic [IDX_W-1:0]    edge_a;
    logic [IDX_W-1:0]    edge_b;
    logic [STEP_W-1:0]   last_step;
    logic                route_bad;
    logic                cyclic;
    logic                release_bad;
    count_t              unit_in;
    logic                unit_at_max;
    logic                unit_is_zero;

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign admitted = admitted_reg;
    assign fault    = fault_reg;

    // The edge being worked on is the pair of stops at the current step.
    assign edge_a    = stops_reg[step_reg][IDX_W-1:0];
    assign edge_b    = stops_reg[step_reg + STEP_W'(1)][IDX_W-1:0];
    assign last_step = STEP_W'(len_reg - LEN_W'(2));

    always_comb
    begin
        route_bad = 1'b0;
        for (int s = 0; s < MAX_STOPS; s++)
        begin
            if ((LEN_W'(s) < len_reg) && ({1'b0, stops_reg[s]} >= STOP_LIMIT))
            begin
                route_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        cyclic = 1'b0;
        for (int i = 0; i < STATIONS; i++)
        begin
            if (reach_reg[i][i])
            begin
                cyclic = 1'b1;
            end
        end
    end

    assign release_bad = ({1'b0, from_reg} >= STOP_LIMIT) || ({1'b0, to_reg} >= STOP_LIMIT);

    // The one count adder: it serves commits and releases alike.
    always_comb
    begin
        if (state_reg == S_RELEASE)
        begin
            unit_in = release_bad ? '0
                    : counts_reg[from_reg[IDX_W-1:0]][to_reg[IDX_W-1:0]];
        end
        else
        begin
            unit_in = counts_reg[edge_a][edge_b];
        end
    end

    assign unit_at_max  = (unit_in == COUNT_MAX);
    assign unit_is_zero = (unit_in == '0);

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        len_next      = len_reg;
        stops_next    = stops_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        step_next     = step_reg;
        pivot_next    = pivot_reg;
        sat_next      = sat_reg;
        reach_next    = reach_reg;
        counts_next   = counts_reg;
        done_next     = 1'b0;
        admitted_next = admitted_reg;
        fault_next    = fault_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next     = func_t'(func);
                    stops_next[0] = stop_0;
                    stops_next[1] = stop_1;
                    stops_next[2] = stop_2;
                    stops_next[3] = stop_3;
                    from_next     = edge_from;
                    to_next       = edge_to;
                    step_next     = '0;
                    pivot_next    = '0;
                    sat_next      = 1'b0;
                    if (route_length == '0)
                    begin
                        len_next = LEN_W'(1);
                    end
                    else if (route_length > LEN_W'(MAX_STOPS))
                    begin
                        len_next = LEN_W'(MAX_STOPS);
                    end
                    else
                    begin
                        len_next = route_length;
                    end
                    // Seed the trial graph with the committed edges.
                    for (int i = 0; i < STATIONS; i++)
                    begin
                        for (int j = 0; j < STATIONS; j++)
                        begin
                            reach_next[i][j] = (i != j) && (counts_reg[i][j] != '0);
                        end
                    end
                    state_next = (func_t'(func) == FUNC_RELEASE) ? S_RELEASE : S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (route_bad)
                begin
                    done_next     = 1'b1;
                    admitted_next = 1'b0;
                    fault_next    = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (len_reg == LEN_W'(1))
                begin
                    done_next     = 1'b1;
                    admitted_next = 1'b1;
                    fault_next    = 1'b0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end

            S_EDGE:
            begin
                // Self-loops play no part in the cycle test.
                if (edge_a != edge_b)
                begin
                    reach_next[edge_a][edge_b] = 1'b1;
                end
                if (step_reg == last_step)
                begin
                    step_next  = '0;
                    state_next = S_CLOSE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            S_CLOSE:
            begin
                // One Warshall pivot per cycle: every row that reaches the
                // pivot takes on the pivot's row.
                for (int i = 0; i < STATIONS; i++)
                begin
                    if (reach_reg[i][pivot_reg])
                    begin
                        reach_next[i] = reach_reg[i] | reach_reg[pivot_reg];
                    end
                end
                if (pivot_reg == LAST_PIVOT)
                begin
                    state_next = S_VERDICT;
                end
                else
                begin
                    pivot_next = pivot_reg + IDX_W'(1);
                end
            end

            S_VERDICT:
            begin
                if (cyclic)
                begin
                    done_next     = 1'b1;
                    admitted_next = 1'b0;
                    fault_next    = 1'b0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end

            S_COMMIT:
            begin
                if (!unit_at_max)
                begin
                    counts_next[edge_a][edge_b] = unit_in + COUNT_WIDTH'(1);
                end
                if (step_reg == last_step)
                begin
                    done_next     = 1'b1;
                    admitted_next = 1'b1;
                    fault_next    = sat_reg | unit_at_max;
                    state_next    = S_IDLE;
                end
                else
                begin
                    sat_next  = sat_reg | unit_at_max;
                    step_next = step_reg + STEP_W'(1);
                end
            end

            S_RELEASE:
            begin
                done_next     = 1'b1;
                admitted_next = 1'b0;
                fault_next    = release_bad | unit_is_zero;
                if (!release_bad && !unit_is_zero)
                begin
                    counts_next[from_reg[IDX_W-1:0]][to_reg[IDX_W-1:0]] =
                        unit_in - COUNT_WIDTH'(1);
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            admitted_reg <= 1'b0;
            fault_reg    <= 1'b0;
            step_reg     <= '0;
            pivot_reg    <= '0;
            for (int i = 0; i < STATIONS; i++)
            begin
                for (int j = 0; j < STATIONS; j++)
                begin
                    counts_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            admitted_reg <= admitted_next;
            fault_reg    <= fault_next;
            step_reg     <= step_next;
            pivot_reg    <= pivot_next;
            counts_reg   <= counts_next;
        end
    end

    // Command payload and trial graph need no reset.
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        len_reg   <= len_next;
        stops_reg <= stops_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        sat_reg   <= sat_next;
        reach_reg <= reach_next;
    end

    // A release never reports an admission.
    a_release_not_admitted: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && admitted_reg) |-> (func_reg == FUNC_ADMIT))
        else $error("release reported as admitted");

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // One result per command: strobes never come in consecutive cycles.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // A cyclic trial graph is refused cleanly, with no commit.
    a_cycle_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VERDICT && cyclic) |=>
            (state_reg == S_IDLE && done_reg && !admitted_reg && !fault_reg))
        else $error("cyclic route not refused");

    // A result only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy))
        else $error("result strobe without a command in flight");

endmodule
